[rtl/hsp_pkg.sv]
// ----------------------------------------------------------------------------
// hsp_pkg: shared definitions of the heat stencil pass
// Widths, register indexes, reciprocal constants and the queue entry type used
// by the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package hsp_pkg;

  localparam int VALUE_BITS    = 32;
  localparam int MAX_WIDTH     = 4096;
  localparam int COL_BITS      = $clog2(MAX_WIDTH);
  localparam int WEFF_BITS     = $clog2(MAX_WIDTH + 1);
  localparam int ROW_BITS      = 16;
  localparam int WCFG_BITS     = 13;
  localparam int HCFG_BITS     = 16;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_WIDTH  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_HEIGHT = CFG_IDX_BITS'(1);
  localparam logic [WCFG_BITS-1:0]    GRID_WIDTH_RST  = WCFG_BITS'(16);
  localparam logic [HCFG_BITS-1:0]    GRID_HEIGHT_RST = HCFG_BITS'(16);

  localparam int IN_TDATA_BITS  = 32;
  localparam int OUT_TDATA_BITS = 64;
  localparam int OUT_PAD_BITS   = OUT_TDATA_BITS - VALUE_BITS - ROW_BITS - COL_BITS;

  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  // Neighbourhood sums: three values per row, nine in total.
  localparam int PSUM_BITS = VALUE_BITS + 2;
  localparam int SUM_BITS  = VALUE_BITS + 4;

  // Division by nine as a multiplication by ceil(2^s / 9).  With s chosen so
  // that 2^s mod 9 is 8, the rounding error of the reciprocal is exactly one
  // and the quotient is exact for every sum below 2^s.
  localparam int          RECIP_SHIFT = SUM_BITS + ((9 - (SUM_BITS % 6)) % 6);
  localparam logic [63:0] RECIP       = ((64'd1 << RECIP_SHIFT) + 64'd1) / 64'd9;
  localparam int          RECIP_BITS  = RECIP_SHIFT - 3;
  localparam int          RLO_BITS    = RECIP_BITS / 2;
  localparam int          RHI_BITS    = RECIP_BITS - RLO_BITS;
  localparam logic [RLO_BITS-1:0] RECIP_LO = RLO_BITS'(RECIP);
  localparam logic [RHI_BITS-1:0] RECIP_HI = RHI_BITS'(RECIP >> RLO_BITS);
  localparam int          PA_BITS     = SUM_BITS + RLO_BITS;
  localparam int          PB_BITS     = SUM_BITS + RHI_BITS;
  localparam int          PROD_BITS   = SUM_BITS + RECIP_BITS;

  typedef logic [VALUE_BITS-1:0] hsp_value_t;

  typedef enum logic [1:0] {
    WIN_LOAD,
    WIN_SHIFT,
    WIN_CLEAR
  } hsp_win_e;

  typedef struct packed {
    logic top;
    logic bot;
    logic lft;
    logic rgt;
  } hsp_edges_t;

  typedef struct packed {
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
    logic                last;
  } hsp_meta_t;

  typedef struct packed {
    logic       emit;
    hsp_win_e   win;
    hsp_edges_t edges;
    hsp_meta_t  meta;
    hsp_value_t above;
    hsp_value_t current;
    hsp_value_t fresh;
  } hsp_op_t;

  typedef struct packed {
    logic                     empty;
    logic [FIFO_CNT_BITS-1:0] count;
  } hsp_fifo_stat_t;

endpackage

[rtl/hsp_ram.sv]
// ----------------------------------------------------------------------------
// hsp_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module hsp_ram #(
  parameter int Width    = 32,
  parameter int Depth    = 4096,
  parameter int AddrBits = $clog2(Depth)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrBits-1:0] waddr_i,
  input  logic [Width-1:0]    wdata_i,
  input  logic [AddrBits-1:0] raddr_i,
  output logic [Width-1:0]    rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/hsp_fifo.sv]
// ----------------------------------------------------------------------------
// hsp_fifo: short queue between front end and back end
// Holds classified operations with their line buffer data.
// ----------------------------------------------------------------------------
module hsp_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  hsp_pkg::hsp_op_t        op_i,
  input  logic                    pop_i,
  output hsp_pkg::hsp_op_t        op_o,
  output hsp_pkg::hsp_fifo_stat_t stat_o
);
  import hsp_pkg::*;

  hsp_op_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_BITS-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_BITS'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_BITS'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + FIFO_CNT_BITS'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - FIFO_CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

  assign op_o         = mem_q[rd_ptr_q];
  assign stat_o.empty = (count_q == '0);
  assign stat_o.count = count_q;

endmodule

[rtl/hsp_front.sv]
// ----------------------------------------------------------------------------
// hsp_front: input acceptance, classification and line buffers
// Tracks the raster position of input and result cells, classifies each beat,
// reads and updates the two line buffers and pushes operations to the queue.
// ----------------------------------------------------------------------------
module hsp_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [hsp_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  logic [hsp_pkg::CFG_DATA_BITS-1:0]    cfg_data_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [hsp_pkg::IN_TDATA_BITS-1:0]    s_axis_tdata,
  input  logic                                 s_axis_tuser,
  input  hsp_pkg::hsp_fifo_stat_t              fifo_stat_i,
  output logic                                 push_o,
  output hsp_pkg::hsp_op_t                     push_op_o,
  output logic                                 frame_clear_o
);
  import hsp_pkg::*;

  logic [WCFG_BITS-1:0] grid_width_q;
  logic [HCFG_BITS-1:0] grid_height_q;
  logic [ROW_BITS-1:0]  in_row_q, out_row_q;
  logic [COL_BITS-1:0]  in_col_q, out_col_q;

  logic                 f1_valid_q, f1_is_cell_q;
  logic [COL_BITS-1:0]  f1_addr_q;
  hsp_op_t              f1_op_q;

  logic [WEFF_BITS-1:0] w_eff;
  logic [HCFG_BITS-1:0] h_eff;
  logic [WEFF_BITS-1:0] in_col_nxt, out_col_nxt;
  logic [ROW_BITS:0]    out_row_nxt;
  logic                 accept, is_flush, draining, cell_ok, flush_ok, op_ok;
  logic                 out_wrap, in_wrap;
  logic [COL_BITS-1:0]  rd_addr;
  hsp_op_t              op_d;
  hsp_value_t           rd_above, rd_current;
  logic                 ram_we;
  logic [FIFO_CNT_BITS:0] credit_used;

  // Effective grid size: width saturated to 2..MAX_WIDTH, height at least 2.
  always_comb begin
    if (grid_width_q < WCFG_BITS'(2)) begin
      w_eff = WEFF_BITS'(2);
    end else if (grid_width_q > WCFG_BITS'(MAX_WIDTH)) begin
      w_eff = WEFF_BITS'(MAX_WIDTH);
    end else begin
      w_eff = WEFF_BITS'(grid_width_q);
    end
    h_eff = (grid_height_q < HCFG_BITS'(2)) ? HCFG_BITS'(2) : grid_height_q;
  end

  // Queue credit counts the operation still in the read stage.
  assign credit_used   = (FIFO_CNT_BITS+1)'(fifo_stat_i.count) + (FIFO_CNT_BITS+1)'(f1_valid_q);
  assign s_axis_tready = credit_used < (FIFO_CNT_BITS+1)'(FIFO_DEPTH);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign frame_clear_o = cfg_we_i && ((cfg_idx_i == CFG_GRID_WIDTH) ||
                                      (cfg_idx_i == CFG_GRID_HEIGHT));

  always_comb begin
    is_flush    = s_axis_tuser;
    draining    = (in_row_q >= h_eff);
    in_col_nxt  = WEFF_BITS'(in_col_q) + WEFF_BITS'(1);
    out_col_nxt = WEFF_BITS'(out_col_q) + WEFF_BITS'(1);
    out_row_nxt = (ROW_BITS+1)'(out_row_q) + (ROW_BITS+1)'(1);
    out_wrap    = (out_col_nxt >= w_eff);
    in_wrap     = (in_col_nxt >= w_eff);
    cell_ok     = !is_flush && !draining && (WEFF_BITS'(in_col_q) < w_eff);
    flush_ok    = is_flush && draining;
    op_ok       = cell_ok || flush_ok;

    op_d            = '0;
    op_d.edges.top  = (out_row_q != '0);
    op_d.edges.bot  = (out_row_nxt < (ROW_BITS+1)'(h_eff));
    op_d.edges.lft  = (out_col_q != '0);
    op_d.edges.rgt  = !out_wrap;
    op_d.meta.row   = out_row_q;
    op_d.meta.col   = out_col_q;
    op_d.meta.last  = (out_row_nxt == (ROW_BITS+1)'(h_eff)) && (out_col_nxt == w_eff);

    if (is_flush) begin
      op_d.emit  = 1'b1;
      op_d.fresh = '0;
      if (out_wrap) begin
        op_d.win = (out_row_nxt >= (ROW_BITS+1)'(h_eff)) ? WIN_CLEAR : WIN_LOAD;
        rd_addr  = '0;
      end else begin
        op_d.win = WIN_SHIFT;
        rd_addr  = out_col_nxt[COL_BITS-1:0];
      end
    end else begin
      op_d.fresh = s_axis_tdata[VALUE_BITS-1:0];
      rd_addr    = in_col_q;
      if (in_col_q == '0) begin
        op_d.emit = (in_row_q >= ROW_BITS'(2));
        op_d.win  = WIN_LOAD;
      end else begin
        op_d.emit = (in_row_q != '0);
        op_d.win  = WIN_SHIFT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= GRID_WIDTH_RST;
      grid_height_q <= GRID_HEIGHT_RST;
      in_row_q      <= '0;
      in_col_q      <= '0;
      out_row_q     <= '0;
      out_col_q     <= '0;
      f1_valid_q    <= 1'b0;
    end else begin
      f1_valid_q <= accept && op_ok;
      if (frame_clear_o) begin
        if (cfg_idx_i == CFG_GRID_WIDTH) begin
          grid_width_q <= cfg_data_i[WCFG_BITS-1:0];
        end else begin
          grid_height_q <= cfg_data_i[HCFG_BITS-1:0];
        end
        in_row_q  <= '0;
        in_col_q  <= '0;
        out_row_q <= '0;
        out_col_q <= '0;
      end else if (accept && op_ok) begin
        if (is_flush && (op_d.win == WIN_CLEAR)) begin
          // Last result of the frame: start over for the next frame.
          in_row_q  <= '0;
          in_col_q  <= '0;
          out_row_q <= '0;
          out_col_q <= '0;
        end else begin
          if (op_d.emit) begin
            if (out_wrap) begin
              out_col_q <= '0;
              out_row_q <= out_row_nxt[ROW_BITS-1:0];
            end else begin
              out_col_q <= out_col_nxt[COL_BITS-1:0];
            end
          end
          if (!is_flush) begin
            if (in_wrap) begin
              in_col_q <= '0;
              in_row_q <= in_row_q + ROW_BITS'(1);
            end else begin
              in_col_q <= in_col_nxt[COL_BITS-1:0];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && op_ok) begin
      f1_op_q      <= op_d;
      f1_addr_q    <= rd_addr;
      f1_is_cell_q <= !is_flush;
    end
  end

  // Line buffers: read in the accept cycle, written back in the next cycle, when
  // the old contents of the current row are at hand.
  assign ram_we = f1_valid_q && f1_is_cell_q;

  hsp_ram #(
    .Width (VALUE_BITS),
    .Depth (MAX_WIDTH)
  ) u_above_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (f1_addr_q),
    .wdata_i (rd_current),
    .raddr_i (rd_addr),
    .rdata_o (rd_above)
  );

  hsp_ram #(
    .Width (VALUE_BITS),
    .Depth (MAX_WIDTH)
  ) u_current_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (f1_addr_q),
    .wdata_i (f1_op_q.fresh),
    .raddr_i (rd_addr),
    .rdata_o (rd_current)
  );

  always_comb begin
    push_op_o         = f1_op_q;
    push_op_o.above   = rd_above;
    push_op_o.current = rd_current;
  end

  assign push_o = f1_valid_q;

endmodule

[rtl/hsp_back.sv]
// ----------------------------------------------------------------------------
// hsp_back: sliding window, neighbourhood sum and division by nine
// Pops operations from the queue, keeps the 2x3 window, and runs the sum and
// reciprocal multiplication through a stall-together pipeline into the output
// register.
// ----------------------------------------------------------------------------
module hsp_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 frame_clear_i,
  input  hsp_pkg::hsp_op_t                     head_i,
  input  hsp_pkg::hsp_fifo_stat_t              stat_i,
  output logic                                 pop_o,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [hsp_pkg::OUT_TDATA_BITS-1:0]   m_axis_tdata,
  output logic                                 m_axis_tlast
);
  import hsp_pkg::*;

  hsp_value_t           win_q [2][3];
  hsp_value_t           colv [3];
  logic                 rowv [3];
  hsp_value_t           ctr;
  logic [PSUM_BITS-1:0] psum_d [3];

  logic                 b1_valid_q, b2_valid_q, d1_valid_q, d2_valid_q, out_valid_q;
  logic [PSUM_BITS-1:0] b1_psum_q [3];
  logic [SUM_BITS-1:0]  b2_sum_q, d1_sum_q;
  logic [PA_BITS-1:0]   d1_pa_q, d2_pa_q;
  logic [PB_BITS-1:0]   d2_pb_q;
  hsp_meta_t            b1_meta_q, b2_meta_q, d1_meta_q, d2_meta_q, out_meta_q;
  hsp_value_t           out_value_q;
  logic [PROD_BITS-1:0] prod;
  logic                 adv;

  assign adv   = !out_valid_q || m_axis_tready;
  assign pop_o = adv && !stat_i.empty;

  always_comb begin
    colv[0] = head_i.above;
    colv[1] = head_i.current;
    colv[2] = head_i.fresh;
    rowv[0] = head_i.edges.top;
    rowv[1] = 1'b1;
    rowv[2] = head_i.edges.bot;
    ctr     = win_q[1][1];
    // Neighbours outside the grid are replaced by the centre cell.
    for (int k = 0; k < 3; k++) begin
      psum_d[k] = PSUM_BITS'((rowv[k] && head_i.edges.lft) ? win_q[0][k] : ctr)
                + PSUM_BITS'(rowv[k] ? win_q[1][k] : ctr)
                + PSUM_BITS'((rowv[k] && head_i.edges.rgt) ? colv[k] : ctr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < 2; s++) begin
        for (int k = 0; k < 3; k++) begin
          win_q[s][k] <= '0;
        end
      end
    end else if (frame_clear_i) begin
      for (int s = 0; s < 2; s++) begin
        for (int k = 0; k < 3; k++) begin
          win_q[s][k] <= '0;
        end
      end
    end else if (pop_o) begin
      case (head_i.win)
        WIN_LOAD: begin
          for (int k = 0; k < 3; k++) begin
            win_q[0][k] <= colv[k];
            win_q[1][k] <= colv[k];
          end
        end
        WIN_SHIFT: begin
          for (int k = 0; k < 3; k++) begin
            win_q[0][k] <= win_q[1][k];
            win_q[1][k] <= colv[k];
          end
        end
        WIN_CLEAR: begin
          for (int s = 0; s < 2; s++) begin
            for (int k = 0; k < 3; k++) begin
              win_q[s][k] <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      b2_valid_q  <= 1'b0;
      d1_valid_q  <= 1'b0;
      d2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      b1_valid_q  <= pop_o && head_i.emit;
      b2_valid_q  <= b1_valid_q;
      d1_valid_q  <= b2_valid_q;
      d2_valid_q  <= d1_valid_q;
      out_valid_q <= d2_valid_q;
    end
  end

  assign prod = (PROD_BITS'(d2_pb_q) << RLO_BITS) + PROD_BITS'(d2_pa_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        b1_psum_q[k] <= psum_d[k];
      end
      b1_meta_q   <= head_i.meta;
      b2_sum_q    <= SUM_BITS'(b1_psum_q[0]) + SUM_BITS'(b1_psum_q[1])
                   + SUM_BITS'(b1_psum_q[2]);
      b2_meta_q   <= b1_meta_q;
      d1_sum_q    <= b2_sum_q;
      d1_pa_q     <= PA_BITS'(b2_sum_q) * PA_BITS'(RECIP_LO);
      d1_meta_q   <= b2_meta_q;
      d2_pa_q     <= d1_pa_q;
      d2_pb_q     <= PB_BITS'(d1_sum_q) * PB_BITS'(RECIP_HI);
      d2_meta_q   <= d1_meta_q;
      out_value_q <= prod[RECIP_SHIFT +: VALUE_BITS];
      out_meta_q  <= d2_meta_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD_BITS{1'b0}}, out_meta_q.col, out_meta_q.row, out_value_q};
  assign m_axis_tlast  = out_meta_q.last;

endmodule

[rtl/heat_stencil_3x3_pass_core.sv]
// ----------------------------------------------------------------------------
// heat_stencil_3x3_pass_core: one Jacobi heat-diffusion pass over a grid
// Cells arrive in raster order; every result is the floor of the sum of the
// cell's 3x3 neighbourhood divided by nine, out-of-grid neighbours taking the
// centre value.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake                    Payload
// cfg       in   cfg_we_i (no wait)           cfg_idx_i, cfg_data_i
// s_axis    in   s_axis_tvalid/tready         tdata: cell_value; tuser: action
// m_axis    out  m_axis_tvalid/tready         tdata: new_value, out_row,
//                                             out_column; tlast: frame_last
//
// One beat is taken per clock while the queue has room. m_axis_tvalid rises once
// the beat completing a neighbourhood has passed the line buffer read stage,
// the queue, and the sum and reciprocal-multiply pipeline of the back end
// (b1, b2, d1, d2) up to its output register.
// Results lag the cell stream by grid_width+1 cells; after a frame the host
// sends grid_width+1 flush beats to drain the last row.
// After reset no clearing pass is needed: line buffer entries not yet written in
// the frame are read only for out-of-grid neighbours, which take the centre value.
// When m_axis stalls, the whole back end holds and the front end keeps taking
// beats until the four-entry queue is full.
//
module heat_stencil_3x3_pass_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration: index 0 grid_width (13 bits), index 1 grid_height (16 bits)
  input  logic                               cfg_we_i,
  input  logic [hsp_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [hsp_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  // Input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata, from bit 0 up: cell_value[31:0]
  input  logic [hsp_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,
  // tuser: action (0 cell, 1 flush)
  input  logic                               s_axis_tuser,
  // Result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata, from bit 0 up: new_value[31:0], out_row[47:32], out_column[59:48],
  // zero padding[63:60]
  output logic [hsp_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
  // tlast: frame_last
  output logic                               m_axis_tlast
);
  import hsp_pkg::*;

  logic           push, pop, frame_clear;
  hsp_op_t        push_op, head_op;
  hsp_fifo_stat_t fifo_stat;

  // Front end: position tracking, beat classification and line buffers.
  hsp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .fifo_stat_i   (fifo_stat),
    .push_o        (push),
    .push_op_o     (push_op),
    .frame_clear_o (frame_clear)
  );

  // Queue that lets the two halves stall independently.
  hsp_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .op_i   (push_op),
    .pop_i  (pop),
    .op_o   (head_op),
    .stat_o (fifo_stat)
  );

  // Back end: window, neighbourhood sum, division by nine, output register.
  hsp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_clear_i (frame_clear),
    .head_i        (head_op),
    .stat_i        (fifo_stat),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
